// ----- design/lagov_pkg.sv -----
`default_nettype none
package lagov_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_SF = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BW = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CR = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DUTY = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OTA = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ANN = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_IDT = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_CAP = 3'd7;

    localparam logic [2:0] VERDICT_OK = 3'd0;
    localparam logic [2:0] VERDICT_SHORT = 3'd1;
    localparam logic [2:0] VERDICT_OTA = 3'd2;
    localparam logic [2:0] VERDICT_BUDGET = 3'd3;
    localparam logic [2:0] VERDICT_THROTTLE = 3'd4;

    localparam logic [7:0] OTA_FIRST = 8'hA0;
    localparam logic [7:0] OTA_LAST = 8'hA3;
    localparam int MIN_PACKET_BYTES = 22;
    localparam int FRAG_HDR_BYTES = 16;
    localparam int FIXED_QUARTERS = 81;
    localparam logic signed [20:0] BUCKET_LIMIT = 21'sd500000;
    localparam logic [47:0] ANNOUNCE_GAP_MS = 48'd30000;

    typedef struct packed {
        logic [3:0] sf;
        logic [1:0] bw;
        logic [3:0] cr;
        logic [5:0] duty;
        logic       ota;
        logic [7:0] ann;
        logic [7:0] idt;
        logic [7:0] cap;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic        governed;
        logic        identity;
        logic [12:0] len;
        logic [63:0] sender;
        logic [47:0] now;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRAG,
        ST_MUL,
        ST_ROUND,
        ST_REFILL,
        ST_SCAN,
        ST_DECIDE,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

// ----- design/lora_airtime_admission_governor_top.sv -----
`default_nettype none
// Judges one packet request at a time: a front stage checks length and type and
// queues up to two requests, and a back sequencer works out the time-on-air per
// fragment in the FRAG, MUL and ROUND states, refills and debits the credit bucket
// and walks the throttle table one entry a cycle. Announce and identity requests
// walk the table; other requests that reach the airtime stage skip the table walk,
// and short or OTA-blocked requests go straight from idle to the output state.
// The user must write configuration only while idle; the block does not enforce it.
module lora_airtime_admission_governor_top
    import lagov_pkg::*;
#(
    parameter int THROTTLE_ENTRIES = 8,
    parameter int MAX_PACKET_BYTES = 512,
    parameter int CHUNK_BYTES = 120
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [9:0]             packet_length,
    input  wire logic [7:0]             packet_type,
    input  wire logic [63:0]            sender_id,
    input  wire logic [47:0]            now_ms,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        admitted,
    output logic [2:0]                  verdict,
    output logic [15:0]                 airtime_ms,
    output logic signed [19:0]          credit_left
);
    cfg_t cfg_reg;
    logic q_valid;
    logic q_pop;
    job_t q_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sf <= 4'd10;
            cfg_reg.bw <= 2'd0;
            cfg_reg.cr <= 4'd5;
            cfg_reg.duty <= 6'd25;
            cfg_reg.ota <= 1'b0;
            cfg_reg.ann <= 8'd1;
            cfg_reg.idt <= 8'd2;
            cfg_reg.cap <= 8'd3;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SF: cfg_reg.sf <= cfg_data[3:0];
                REG_BW: cfg_reg.bw <= cfg_data[1:0];
                REG_CR: cfg_reg.cr <= cfg_data[3:0];
                REG_DUTY: cfg_reg.duty <= cfg_data[5:0];
                REG_OTA: cfg_reg.ota <= cfg_data[0];
                REG_ANN: cfg_reg.ann <= cfg_data;
                REG_IDT: cfg_reg.idt <= cfg_data;
                REG_CAP: cfg_reg.cap <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    lagov_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .packet_length(packet_length),
        .packet_type(packet_type),
        .sender_id(sender_id),
        .now_ms(now_ms),
        .q_valid(q_valid),
        .q_pop(q_pop),
        .q_job(q_job)
    );

    lagov_back #(
        .THROTTLE_ENTRIES(THROTTLE_ENTRIES),
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .q_valid(q_valid),
        .q_pop(q_pop),
        .q_job(q_job),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .admitted(admitted),
        .verdict(verdict),
        .airtime_ms(airtime_ms),
        .credit_left(credit_left)
    );

`ifndef SYNTHESIS
    a_admit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (admitted == (verdict == VERDICT_OK)))
        else $error("admitted flag disagrees with verdict");
    a_blocked_air: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (verdict == VERDICT_SHORT || verdict == VERDICT_OTA)
        |-> airtime_ms == 16'd0)
        else $error("refused request shows airtime");
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (credit_left <= 20'sd500000 && credit_left >= -20'sd500000))
        else $error("credit out of range");
`endif
endmodule
`default_nettype wire

// ----- design/lagov_front.sv -----
`default_nettype none
module lagov_front
    import lagov_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 512
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [9:0]  packet_length,
    input  wire logic [7:0]  packet_type,
    input  wire logic [63:0] sender_id,
    input  wire logic [47:0] now_ms,
    output logic             q_valid,
    input  wire logic        q_pop,
    output job_t             q_job
);
    localparam int DEPTH = 2;

    job_t        q_reg [DEPTH];
    job_t        q_next_job;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic        push;
    logic [12:0] len_sat;
    logic        ident;

    assign in_stall = (cnt_reg == 2'(DEPTH));
    assign push = in_valid && !in_stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_job = q_reg[rd_ptr_reg];

    always_comb
    begin
        len_sat = (13'(packet_length) > 13'(MAX_PACKET_BYTES)) ?
            13'(MAX_PACKET_BYTES) : 13'(packet_length);
        ident = (packet_type == cfg.ann) || (packet_type == cfg.idt);
        q_next_job.len = len_sat;
        q_next_job.sender = sender_id;
        q_next_job.now = now_ms;
        q_next_job.identity = ident;
        q_next_job.governed = ident || (packet_type == cfg.cap);
        if (len_sat < 13'(MIN_PACKET_BYTES))
        begin
            q_next_job.verdict = VERDICT_SHORT;
        end
        else if (packet_type >= OTA_FIRST && packet_type <= OTA_LAST && !cfg.ota)
        begin
            q_next_job.verdict = VERDICT_OTA;
        end
        else
        begin
            q_next_job.verdict = VERDICT_OK;
        end
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= q_next_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end
endmodule
`default_nettype wire

// ----- design/lagov_back.sv -----
`default_nettype none
module lagov_back
    import lagov_pkg::*;
#(
    parameter int THROTTLE_ENTRIES = 8,
    parameter int CHUNK_BYTES = 120
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               q_valid,
    output logic                    q_pop,
    input  wire job_t               q_job,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    admitted,
    output logic [2:0]              verdict,
    output logic [15:0]             airtime_ms,
    output logic signed [19:0]      credit_left
);
    localparam int IX_W = (THROTTLE_ENTRIES > 1) ? $clog2(THROTTLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(THROTTLE_ENTRIES + 1);

    state_t state_reg, state_next;
    job_t   job_reg;
    logic [12:0] rem_reg;
    logic [15:0] air_reg;
    logic [31:0] us_reg;
    logic [11:0] qtr_reg;
    logic signed [20:0] credit_reg;
    logic [47:0] last_reg;
    logic [THROTTLE_ENTRIES-1:0] ovalid_reg;
    logic [63:0] otag_reg [THROTTLE_ENTRIES];
    logic [47:0] otime_reg [THROTTLE_ENTRIES];
    logic [CNT_W-1:0] scan_reg;
    logic        match_f_reg, free_f_reg;
    logic [IX_W-1:0] match_reg, free_reg, oldest_reg;
    logic [2:0]  vout_reg;
    logic [15:0] aout_reg;
    logic        ovalid_out_reg;
    logic [2:0]  vres_reg;
    logic signed [19:0] cout_reg;

    logic [3:0] sf;
    logic [1:0] bs;
    logic [3:0] cr;
    logic       de;
    logic [3:0] dsym;
    logic [12:0] chunk;
    logic [13:0] num;
    logic [5:0]  den;
    logic [13:0] num_up;
    logic [9:0]  nsym_m;
    logic [11:0] recip;
    logic [21:0] nsym_prod;
    logic [13:0] nsym_div;
    logic [11:0] quarters;
    logic [24:0] us_round;
    logic [44:0] ms_prod;
    logic [15:0] frame;
    logic [16:0] air_sum;
    logic [47:0] delta;
    logic [53:0] refill;
    logic signed [21:0] cr_sum;
    logic signed [23:0] cost;
    logic signed [23:0] debit;
    logic [IX_W-1:0] six;
    logic [IX_W-1:0] pick;
    logic        hit;

    always_comb
    begin
        sf = (cfg.sf < 4'd7) ? 4'd7 : ((cfg.sf > 4'd12) ? 4'd12 : cfg.sf);
        bs = (cfg.bw > 2'd2) ? 2'd2 : cfg.bw;
        cr = (cfg.cr < 4'd5) ? 4'd5 : ((cfg.cr > 4'd8) ? 4'd8 : cfg.cr);
        de = ((sf >= 4'd11) && (bs == 2'd0)) || ((sf >= 4'd12) && (bs == 2'd1));
        dsym = sf - (de ? 4'd2 : 4'd0);
        chunk = (rem_reg < 13'(CHUNK_BYTES)) ? rem_reg : 13'(CHUNK_BYTES);
        num = 14'(8 * (32'(chunk) + FRAG_HDR_BYTES) + 44);
        num = (num > 14'(4 * sf)) ? num - 14'(4 * sf) : 14'd0;
        den = {dsym, 2'b00};
        num_up = num + 14'(den) - 14'd1;
        nsym_m = num_up[11:2];
        // The symbol divisor is 7..12 here, so a 12-bit reciprocal scaled by 2^14 is exact.
        case (dsym)
            4'd7: recip = 12'd2341;
            4'd8: recip = 12'd2048;
            4'd9: recip = 12'd1821;
            4'd10: recip = 12'd1639;
            4'd11: recip = 12'd1490;
            default: recip = 12'd1366;
        endcase
        nsym_prod = 22'(nsym_m) * 22'(recip);
        nsym_div = 14'(nsym_prod[21:14]);
        quarters = 12'(FIXED_QUARTERS + 4 * 32'(nsym_div) * 32'(cr));
        us_round = 25'(us_reg + 32'd500);
        ms_prod = 45'(us_round[24:3]) * 45'(23'd4294968);
        frame = ms_prod[44:29];
        air_sum = 17'(air_reg) + 17'(frame);
        delta = job_reg.now - last_reg;
        refill = 54'(delta) * 54'(cfg.duty);
        cr_sum = 22'(credit_reg) +
            ((refill > 54'd1000000) ? 22'sd1000000 : 22'(refill));
        cost = 24'(air_reg) * 24'sd100;
        debit = 24'(credit_reg) - cost;
        six = IX_W'(scan_reg);
        pick = match_f_reg ? match_reg : (free_f_reg ? free_reg : oldest_reg);
        hit = match_f_reg &&
            ((job_reg.now - otime_reg[match_reg]) < ANNOUNCE_GAP_MS);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid)
                begin
                    state_next = (q_job.verdict == VERDICT_OK) ? ST_FRAG : ST_OUT;
                end
            ST_FRAG:
                state_next = (rem_reg == 13'd0) ? ST_REFILL : ST_MUL;
            ST_MUL:
                state_next = ST_ROUND;
            ST_ROUND:
                state_next = ST_FRAG;
            ST_REFILL:
                state_next = (job_reg.governed && job_reg.identity) ? ST_SCAN : ST_DECIDE;
            ST_SCAN:
                if (scan_reg == CNT_W'(THROTTLE_ENTRIES - 1))
                begin
                    state_next = ST_DECIDE;
                end
            ST_DECIDE:
                state_next = ST_OUT;
            ST_OUT:
                if (!(ovalid_out_reg && out_stall))
                begin
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = (state_reg == ST_IDLE) && q_valid;
        out_valid = ovalid_out_reg;
        verdict = vres_reg;
        admitted = (vres_reg == VERDICT_OK);
        airtime_ms = aout_reg;
        credit_left = cout_reg;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (q_valid)
                begin
                    job_reg <= q_job;
                    rem_reg <= q_job.len;
                    air_reg <= 16'd0;
                end
            ST_FRAG:
                qtr_reg <= quarters;
            ST_MUL:
            begin
                unique case (bs)
                    2'd0: us_reg <= 32'(qtr_reg) << (sf + 4'd1);
                    2'd1: us_reg <= 32'(qtr_reg) << sf;
                    default: us_reg <= 32'(qtr_reg) << (sf - 4'd1);
                endcase
                rem_reg <= rem_reg - chunk;
            end
            ST_ROUND:
                air_reg <= air_sum[16] ? 16'hFFFF : air_sum[15:0];
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            credit_reg <= BUCKET_LIMIT;
            last_reg <= 48'd0;
            ovalid_reg <= '0;
            for (int i = 0; i < THROTTLE_ENTRIES; i++)
            begin
                otime_reg[i] <= 48'd0;
            end
            scan_reg <= '0;
            match_f_reg <= 1'b0;
            free_f_reg <= 1'b0;
            match_reg <= '0;
            free_reg <= '0;
            oldest_reg <= '0;
            vout_reg <= VERDICT_OK;
            aout_reg <= 16'd0;
            ovalid_out_reg <= 1'b0;
            vres_reg <= VERDICT_OK;
            cout_reg <= 20'sd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && !(ovalid_out_reg && out_stall))
            begin
                ovalid_out_reg <= 1'b1;
            end
            else if (ovalid_out_reg && !out_stall)
            begin
                ovalid_out_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    scan_reg <= '0;
                    match_f_reg <= 1'b0;
                    free_f_reg <= 1'b0;
                    oldest_reg <= '0;
                    if (q_valid)
                    begin
                        vout_reg <= q_job.verdict;
                    end
                end
                ST_REFILL:
                begin
                    credit_reg <= (cr_sum > 22'(BUCKET_LIMIT)) ?
                        BUCKET_LIMIT : 21'(cr_sum);
                    last_reg <= job_reg.now;
                end
                ST_SCAN:
                begin
                    scan_reg <= scan_reg + 1'b1;
                    if (ovalid_reg[six] && otag_reg[six] == job_reg.sender)
                    begin
                        match_f_reg <= 1'b1;
                        match_reg <= six;
                    end
                    else if (!ovalid_reg[six] && !free_f_reg)
                    begin
                        free_f_reg <= 1'b1;
                        free_reg <= six;
                    end
                    if (otime_reg[six] < otime_reg[oldest_reg])
                    begin
                        oldest_reg <= six;
                    end
                end
                ST_DECIDE:
                begin
                    if (job_reg.governed && (24'(credit_reg) < cost))
                    begin
                        vout_reg <= VERDICT_BUDGET;
                    end
                    else if (job_reg.governed && job_reg.identity && hit)
                    begin
                        vout_reg <= VERDICT_THROTTLE;
                    end
                    else
                    begin
                        if (job_reg.governed && job_reg.identity)
                        begin
                            ovalid_reg[pick] <= 1'b1;
                            otime_reg[pick] <= job_reg.now;
                        end
                        credit_reg <= (debit < -24'(BUCKET_LIMIT)) ?
                            -BUCKET_LIMIT : 21'(debit);
                    end
                end
                ST_OUT:
                    if (!(ovalid_out_reg && out_stall))
                    begin
                        vres_reg <= vout_reg;
                        cout_reg <= 20'(credit_reg);
                        aout_reg <= (vout_reg == VERDICT_SHORT ||
                            vout_reg == VERDICT_OTA) ? 16'd0 : air_reg;
                    end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DECIDE && job_reg.governed && job_reg.identity &&
            !(24'(credit_reg) < cost) && !hit && !match_f_reg)
        begin
            otag_reg[pick] <= job_reg.sender;
        end
    end
endmodule
`default_nettype wire
